// ===== rtl/order_book_level_aggregator_assert.svh =====
// ---------------------------------------------------------------------------
// Order book level aggregator assertion macros
// Concurrent assertion helpers clocked on aclk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ORDER_BOOK_LEVEL_AGGREGATOR_ASSERT_SVH
`define ORDER_BOOK_LEVEL_AGGREGATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define OBLA_ASSERT(name, expr) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("order book assertion failed");
`define OBLA_IMPLIES(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("order book assertion failed");
`else
`define OBLA_ASSERT(name, expr)
`define OBLA_IMPLIES(name, pre, post)
`endif
`endif

// ===== rtl/obla_pkg.sv =====
// ---------------------------------------------------------------------------
// Order book level aggregator package
// Request, row, level and slot types, action and side codes, limits and default sizes.
// ---------------------------------------------------------------------------
package obla_pkg;

    localparam int BOOK_LEVELS_DEF = 64;
    localparam int TOP_LEVELS_DEF  = 10;
    localparam int ORDER_SLOTS_DEF = 4096;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_TRADE  = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;

    localparam logic [1:0] SIDE_BID = 2'd0;
    localparam logic [1:0] SIDE_ASK = 2'd1;

    localparam logic [47:0] SIZE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  side;
        logic [39:0] price;
        logic [31:0] quantity;
        logic [63:0] order_key;
        logic [63:0] event_time;
    } in_t;

    typedef struct packed {
        logic [63:0]        row_time;
        logic [3:0]         depth_index;
        logic               ask_present;
        logic [39:0]        ask_price;
        logic [47:0]        ask_total;
        logic signed [15:0] ask_orders;
        logic               bid_present;
        logic [39:0]        bid_price;
        logic [47:0]        bid_total;
        logic signed [15:0] bid_orders;
        logic               last_row;
        logic               overflow;
    } out_t;

    typedef struct packed {
        logic [39:0]        price;
        logic [47:0]        size;
        logic signed [15:0] count;
    } level_t;

    typedef struct packed {
        level_t ask;
        level_t bid;
    } level_pair_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  side;
        logic [39:0] price;
        logic [63:0] key;
    } slot_t;

endpackage

// ===== rtl/order_book_level_aggregator.sv =====
// ---------------------------------------------------------------------------
// Order book level aggregator
// Turns market-by-order requests into sorted price levels and depth rows.
// ---------------------------------------------------------------------------
// Bid and ask levels share one synchronous memory (one entry per rank, one
// half per side) and orders sit in a direct-mapped slot memory indexed by the
// low bits of the order key, so ORDER_SLOTS must be a power of two. After
// reset the block clears every entry of the slot memory before it takes
// its first request. A request then goes through the slot lookup, the
// level search and update, a move of entries when an insert or a removal
// shifts them, and the streaming of TOP_LEVELS snapshot rows, one level
// memory read per row, which the receiver can hold off. A request that
// touches no level skips the search and update. A fill request is taken
// in the idle state and produces no rows.
module order_book_level_aggregator #(
    parameter int BOOK_LEVELS = obla_pkg::BOOK_LEVELS_DEF,
    parameter int TOP_LEVELS  = obla_pkg::TOP_LEVELS_DEF,
    parameter int ORDER_SLOTS = obla_pkg::ORDER_SLOTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  obla_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output obla_pkg::out_t m_data
);

`include "order_book_level_aggregator_assert.svh"

    localparam int LW = (BOOK_LEVELS > 1) ? $clog2(BOOK_LEVELS) : 1;
    localparam int UW = $clog2(BOOK_LEVELS + 1);
    localparam int KW = $clog2(TOP_LEVELS + 1);
    localparam int SW = $clog2(ORDER_SLOTS);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_SLOT  = 9'b000000100,
        ST_SCAN  = 9'b000001000,
        ST_ACT   = 9'b000010000,
        ST_MU    = 9'b000100000,
        ST_INS   = 9'b001000000,
        ST_MD    = 9'b010000000,
        ST_SNAP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    obla_pkg::in_t req_reg, req_next;
    logic ovf_reg, ovf_next;
    logic tgt_bid_reg, tgt_bid_next;
    logic grow_reg, grow_next;
    logic [39:0] eprice_reg, eprice_next;
    logic [UW-1:0] bid_used_reg, bid_used_next;
    logic [UW-1:0] ask_used_reg, ask_used_next;
    logic [UW-1:0] si_reg, si_next;
    logic live_reg, live_next;
    logic found_reg, found_next;
    logic [UW-1:0] pos_reg, pos_next;
    logic [UW-1:0] wj_reg, wj_next;
    logic [KW-1:0] rd_k_reg, rd_k_next;
    logic [KW-1:0] pk_reg, pk_next;
    logic pend_reg, pend_next;
    logic m_valid_reg, m_valid_next;
    obla_pkg::out_t m_data_reg, m_data_next;
    logic [SW-1:0] clr_idx_reg, clr_idx_next;

    obla_pkg::level_pair_t lvl_mem [BOOK_LEVELS];
    obla_pkg::level_pair_t lvl_q_reg;
    obla_pkg::slot_t ord_mem [ORDER_SLOTS];
    obla_pkg::slot_t ord_q_reg;

    logic lv_rd_en;
    logic [LW-1:0] lv_rd_addr;
    logic lv_we_bid, lv_we_ask;
    logic [LW-1:0] lv_waddr;
    obla_pkg::level_t lv_wdata;
    logic ord_rd_en;
    logic [SW-1:0] ord_rd_addr;
    logic ord_we;
    logic [SW-1:0] ord_waddr;
    obla_pkg::slot_t ord_wdata;

    logic [UW-1:0] cur_used;
    obla_pkg::level_t ent;
    obla_pkg::level_t new_ent;
    logic ent_eq, ent_better;
    logic [48:0] size_sum;
    logic used_wr;
    logic [UW-1:0] used_val;
    logic [UW-1:0] u_eff;
    logic load;
    logic issue;

    always_ff @(posedge aclk) begin
        if (lv_rd_en) begin
            lvl_q_reg <= lvl_mem[lv_rd_addr];
        end
        if (lv_we_bid) begin
            lvl_mem[lv_waddr].bid <= lv_wdata;
        end
        if (lv_we_ask) begin
            lvl_mem[lv_waddr].ask <= lv_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ord_rd_en) begin
            ord_q_reg <= ord_mem[ord_rd_addr];
        end
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
    end

    assign cur_used = tgt_bid_reg ? bid_used_reg : ask_used_reg;
    assign ent = tgt_bid_reg ? lvl_q_reg.bid : lvl_q_reg.ask;
    assign ent_eq = (ent.price == eprice_reg);
    assign ent_better = tgt_bid_reg ? (eprice_reg > ent.price) : (eprice_reg < ent.price);
    assign size_sum = {1'b0, ent.size} + 49'(req_reg.quantity);
    assign u_eff = (cur_used == UW'(BOOK_LEVELS)) ? UW'(BOOK_LEVELS - 1) : cur_used;

    always_comb begin
        new_ent.price = eprice_reg;
        new_ent.size  = 48'(req_reg.quantity);
        new_ent.count = 16'sd1;
    end

    assign load  = pend_reg && (!m_valid_reg || m_ready);
    assign issue = (state_reg == ST_SNAP) && (32'(rd_k_reg) < TOP_LEVELS)
                   && (!pend_reg || load);

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        ovf_next      = ovf_reg;
        tgt_bid_next  = tgt_bid_reg;
        grow_next     = grow_reg;
        eprice_next   = eprice_reg;
        si_next       = si_reg;
        live_next     = live_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        wj_next       = wj_reg;
        rd_k_next     = rd_k_reg;
        pk_next       = pk_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        clr_idx_next  = clr_idx_reg;
        used_wr       = 1'b0;
        used_val      = cur_used;
        lv_rd_en      = 1'b0;
        lv_rd_addr    = '0;
        lv_we_bid     = 1'b0;
        lv_we_ask     = 1'b0;
        lv_waddr      = LW'(pos_reg);
        lv_wdata      = new_ent;
        ord_rd_en     = 1'b0;
        ord_rd_addr   = s_data.order_key[SW-1:0];
        ord_we        = 1'b0;
        ord_waddr     = req_reg.order_key[SW-1:0];
        ord_wdata     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ord_we       = 1'b1;
                ord_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SW'(ORDER_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    ovf_next = 1'b0;
                    if (s_data.opcode != obla_pkg::OP_FILL) begin
                        ord_rd_en  = 1'b1;
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_SLOT: begin
                state_next = ST_SNAP;
                if (req_reg.opcode == obla_pkg::OP_ADD) begin
                    ovf_next = ord_q_reg.valid && (ord_q_reg.key != req_reg.order_key);
                    ord_we          = 1'b1;
                    ord_wdata.valid = 1'b1;
                    ord_wdata.side  = req_reg.side;
                    ord_wdata.price = req_reg.price;
                    ord_wdata.key   = req_reg.order_key;
                    grow_next   = 1'b1;
                    eprice_next = req_reg.price;
                    tgt_bid_next = (req_reg.side == obla_pkg::SIDE_BID);
                    if (req_reg.side == obla_pkg::SIDE_BID
                        || req_reg.side == obla_pkg::SIDE_ASK) begin
                        state_next = ST_SCAN;
                    end
                end else if (req_reg.opcode == obla_pkg::OP_CANCEL) begin
                    grow_next    = 1'b0;
                    eprice_next  = ord_q_reg.price;
                    tgt_bid_next = (ord_q_reg.side == obla_pkg::SIDE_BID);
                    if (ord_q_reg.valid && ord_q_reg.key == req_reg.order_key) begin
                        ord_we    = 1'b1;
                        ord_wdata = ord_q_reg;
                        ord_wdata.valid = 1'b0;
                        if (ord_q_reg.side == obla_pkg::SIDE_BID
                            || ord_q_reg.side == obla_pkg::SIDE_ASK) begin
                            state_next = ST_SCAN;
                        end
                    end
                end else if (req_reg.opcode == obla_pkg::OP_TRADE) begin
                    grow_next    = 1'b0;
                    eprice_next  = req_reg.price;
                    tgt_bid_next = (req_reg.side == obla_pkg::SIDE_ASK);
                    if (req_reg.side == obla_pkg::SIDE_BID
                        || req_reg.side == obla_pkg::SIDE_ASK) begin
                        state_next = ST_SCAN;
                    end
                end
                if (state_next == ST_SCAN) begin
                    lv_rd_en   = 1'b1;
                    lv_rd_addr = '0;
                    si_next    = '0;
                    live_next  = tgt_bid_next ? (bid_used_reg != '0) : (ask_used_reg != '0);
                end
            end
            ST_SCAN: begin
                if (!live_reg) begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_ACT;
                end else if (ent_eq) begin
                    found_next = 1'b1;
                    pos_next   = si_reg;
                    state_next = ST_ACT;
                end else if (ent_better) begin
                    found_next = 1'b0;
                    pos_next   = si_reg;
                    state_next = ST_ACT;
                end else if (UW'(si_reg + 1'b1) == cur_used) begin
                    found_next = 1'b0;
                    pos_next   = cur_used;
                    state_next = ST_ACT;
                end else begin
                    lv_rd_en   = 1'b1;
                    lv_rd_addr = LW'(si_reg + 1'b1);
                    si_next    = si_reg + 1'b1;
                end
            end
            ST_ACT: begin
                state_next = ST_SNAP;
                lv_waddr   = LW'(pos_reg);
                if (grow_reg && found_reg) begin
                    lv_wdata.price = ent.price;
                    lv_wdata.size  = size_sum[48] ? obla_pkg::SIZE_MAX : size_sum[47:0];
                    lv_wdata.count = (ent.count != obla_pkg::COUNT_MAX)
                                     ? ent.count + 16'sd1 : ent.count;
                    lv_we_bid = tgt_bid_reg;
                    lv_we_ask = !tgt_bid_reg;
                end else if (grow_reg) begin
                    if (pos_reg == UW'(BOOK_LEVELS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        if (cur_used == UW'(BOOK_LEVELS)) begin
                            ovf_next = 1'b1;
                        end
                        if (pos_reg == u_eff) begin
                            lv_wdata  = new_ent;
                            lv_we_bid = tgt_bid_reg;
                            lv_we_ask = !tgt_bid_reg;
                            used_wr   = 1'b1;
                            used_val  = u_eff + 1'b1;
                        end else begin
                            used_wr    = 1'b1;
                            used_val   = u_eff;
                            lv_rd_en   = 1'b1;
                            lv_rd_addr = LW'(u_eff - 1'b1);
                            wj_next    = u_eff;
                            state_next = ST_MU;
                        end
                    end
                end else if (found_reg) begin
                    if (48'(req_reg.quantity) >= ent.size) begin
                        if (UW'(pos_reg + 1'b1) == cur_used) begin
                            used_wr  = 1'b1;
                            used_val = cur_used - 1'b1;
                        end else begin
                            lv_rd_en   = 1'b1;
                            lv_rd_addr = LW'(pos_reg + 1'b1);
                            wj_next    = pos_reg;
                            state_next = ST_MD;
                        end
                    end else begin
                        lv_wdata.price = ent.price;
                        lv_wdata.size  = ent.size - 48'(req_reg.quantity);
                        lv_wdata.count = (ent.count != obla_pkg::COUNT_MIN)
                                         ? ent.count - 16'sd1 : ent.count;
                        lv_we_bid = tgt_bid_reg;
                        lv_we_ask = !tgt_bid_reg;
                    end
                end
            end
            ST_MU: begin
                lv_waddr  = LW'(wj_reg);
                lv_wdata  = ent;
                lv_we_bid = tgt_bid_reg;
                lv_we_ask = !tgt_bid_reg;
                if (UW'(wj_reg - 1'b1) == pos_reg) begin
                    state_next = ST_INS;
                end else begin
                    lv_rd_en   = 1'b1;
                    lv_rd_addr = LW'(wj_reg - 2'd2);
                    wj_next    = wj_reg - 1'b1;
                end
            end
            ST_INS: begin
                lv_waddr   = LW'(pos_reg);
                lv_wdata   = new_ent;
                lv_we_bid  = tgt_bid_reg;
                lv_we_ask  = !tgt_bid_reg;
                used_wr    = 1'b1;
                used_val   = cur_used + 1'b1;
                state_next = ST_SNAP;
            end
            ST_MD: begin
                lv_waddr  = LW'(wj_reg);
                lv_wdata  = ent;
                lv_we_bid = tgt_bid_reg;
                lv_we_ask = !tgt_bid_reg;
                if (UW'(wj_reg + 2'd2) == cur_used) begin
                    used_wr    = 1'b1;
                    used_val   = cur_used - 1'b1;
                    state_next = ST_SNAP;
                end else begin
                    lv_rd_en   = 1'b1;
                    lv_rd_addr = LW'(wj_reg + 2'd2);
                    wj_next    = wj_reg + 1'b1;
                end
            end
            ST_SNAP: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_data_next.row_time    = req_reg.event_time;
                    m_data_next.depth_index = 4'(pk_reg);
                    m_data_next.ask_present = 32'(pk_reg) < 32'(ask_used_reg);
                    m_data_next.ask_price   = m_data_next.ask_present ? lvl_q_reg.ask.price : '0;
                    m_data_next.ask_total   = m_data_next.ask_present ? lvl_q_reg.ask.size : '0;
                    m_data_next.ask_orders  = m_data_next.ask_present ? lvl_q_reg.ask.count : '0;
                    m_data_next.bid_present = 32'(pk_reg) < 32'(bid_used_reg);
                    m_data_next.bid_price   = m_data_next.bid_present ? lvl_q_reg.bid.price : '0;
                    m_data_next.bid_total   = m_data_next.bid_present ? lvl_q_reg.bid.size : '0;
                    m_data_next.bid_orders  = m_data_next.bid_present ? lvl_q_reg.bid.count : '0;
                    m_data_next.last_row    = (32'(pk_reg) == TOP_LEVELS - 1);
                    m_data_next.overflow    = ovf_reg;
                    pend_next = 1'b0;
                    if (32'(pk_reg) == TOP_LEVELS - 1) begin
                        rd_k_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
                if (issue) begin
                    lv_rd_en   = 1'b1;
                    lv_rd_addr = LW'(rd_k_reg);
                    pk_next    = rd_k_reg;
                    rd_k_next  = rd_k_reg + 1'b1;
                    pend_next  = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        bid_used_next = (used_wr && tgt_bid_reg) ? used_val : bid_used_reg;
        ask_used_next = (used_wr && !tgt_bid_reg) ? used_val : ask_used_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            bid_used_reg <= '0;
            ask_used_reg <= '0;
            rd_k_reg     <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            clr_idx_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            bid_used_reg <= bid_used_next;
            ask_used_reg <= ask_used_next;
            rd_k_reg     <= rd_k_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        ovf_reg     <= ovf_next;
        tgt_bid_reg <= tgt_bid_next;
        grow_reg    <= grow_next;
        eprice_reg  <= eprice_next;
        si_reg      <= si_next;
        live_reg    <= live_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        wj_reg      <= wj_next;
        pk_reg      <= pk_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `OBLA_ASSERT(a_bid_used_bound, 32'(bid_used_reg) <= BOOK_LEVELS)
    `OBLA_ASSERT(a_ask_used_bound, 32'(ask_used_reg) <= BOOK_LEVELS)
    `OBLA_IMPLIES(a_pend_in_snap, pend_reg, state_reg == ST_SNAP)
    `OBLA_IMPLIES(a_move_up_above_pos, state_reg == ST_MU, wj_reg > pos_reg)
    `OBLA_IMPLIES(a_move_down_in_book, state_reg == ST_MD, UW'(wj_reg + 1'b1) < cur_used)

endmodule
